### design/x86_instruction_field_decoder_core_defines.svh
// assertion macros shared by the checker of the x86 field decoder
// no dependencies; each macro takes clock, active-low reset, antecedent and consequent
`ifndef X86_INSTRUCTION_FIELD_DECODER_CORE_DEFINES_SVH
`define X86_INSTRUCTION_FIELD_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define X86FD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("x86fd: same-cycle check failed");

// next-cycle implication
`define X86FD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("x86fd: next-cycle check failed");

`endif

### design/x86fd_pkg.sv
// types and constants of the x86 instruction field decoder
// no dependencies; used by the step logic and the top level
package x86fd_pkg;

	localparam int OPCODE_SPACE = 512;
	localparam int ATTR_W       = 6;

	// prefix and escape bytes
	localparam logic [7:0] PFX_ES     = 8'h26;
	localparam logic [7:0] PFX_CS     = 8'h2e;
	localparam logic [7:0] PFX_SS     = 8'h36;
	localparam logic [7:0] PFX_DS     = 8'h3e;
	localparam logic [7:0] PFX_FS     = 8'h64;
	localparam logic [7:0] PFX_GS     = 8'h65;
	localparam logic [7:0] PFX_OPSIZE = 8'h66;
	localparam logic [7:0] PFX_ADSIZE = 8'h67;
	localparam logic [7:0] PFX_REPNZ  = 8'hf2;
	localparam logic [7:0] PFX_REPZ   = 8'hf3;
	localparam logic [7:0] OPC_ESCAPE = 8'h0f;
	localparam logic [8:0] ESC_BASE   = 9'h100;

	// segment override codes
	localparam logic [2:0] SEG_ES = 3'd1;
	localparam logic [2:0] SEG_CS = 3'd2;
	localparam logic [2:0] SEG_SS = 3'd3;
	localparam logic [2:0] SEG_DS = 3'd4;
	localparam logic [2:0] SEG_FS = 3'd5;
	localparam logic [2:0] SEG_GS = 3'd6;

	// repeat prefix codes
	localparam logic [1:0] REP_NZ = 2'd1;
	localparam logic [1:0] REP_Z  = 2'd2;

	// size flip bits
	localparam int FLIP_OPER = 0;
	localparam int FLIP_ADDR = 1;

	// attribute bits
	localparam int AT_MODRM = 0;
	localparam int AT_IMM32 = 1;
	localparam int AT_IMM16 = 2;
	localparam int AT_IMM8  = 3;
	localparam int AT_PTR16 = 4;
	localparam int AT_MOFFS = 5;

	// input operations
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_TABLE = 1'b1;

	// register index on the configuration port
	localparam logic REG_MODE32 = 1'b0;

	localparam logic [3:0] LEN_MAX = 4'd15;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_ESC,
		PH_MODRM,
		PH_SIB,
		PH_DISP,
		PH_IMM,
		PH_PTR,
		PH_MOFFS
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  left;
		logic [2:0]  len;
		logic [1:0]  pos;
		logic [31:0] acc;
		logic [3:0]  count;
		logic [2:0]  seg;
		logic [1:0]  rep;
		logic [1:0]  flips;
		logic [8:0]  opcode;
		logic [7:0]  modrm;
		logic [7:0]  sib;
		logic [5:0]  attr;
		logic [31:0] disp;
		logic [31:0] imm;
		logic [15:0] sel;
		logic [31:0] moffs;
	} dec_state_t;

	localparam dec_state_t DEC_CLEAR = '{
		phase: PH_PREFIX, left: 3'd0, len: 3'd0, pos: 2'd0, acc: 32'd0,
		count: 4'd0, seg: 3'd0, rep: 2'd0, flips: 2'd0, opcode: 9'd0,
		modrm: 8'd0, sib: 8'd0, attr: 6'd0, disp: 32'd0, imm: 32'd0,
		sel: 16'd0, moffs: 32'd0
	};

	typedef struct packed {
		logic [2:0]         segment_override;
		logic [1:0]         repeat_prefix;
		logic               operand_size_flip;
		logic               address_size_flip;
		logic [8:0]         opcode;
		logic [7:0]         modrm;
		logic [7:0]         sib;
		logic signed [31:0] displacement;
		logic signed [31:0] immediate;
		logic [15:0]        far_selector;
		logic [31:0]        memory_offset;
		logic [3:0]         length;
	} dec_result_t;

endpackage

### design/x86fd_if.sv
// valid/ready channels of the x86 field decoder: code item in, decoded item out
// no dependencies
interface x86fd_code_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] code_byte;
	logic [8:0] table_index;
	logic [5:0] table_flags;

	modport source (output valid, op, code_byte, table_index, table_flags, input ready);
	modport sink (input valid, op, code_byte, table_index, table_flags, output ready);
endinterface

interface x86fd_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         segment_override;
	logic [1:0]         repeat_prefix;
	logic               operand_size_flip;
	logic               address_size_flip;
	logic [8:0]         opcode;
	logic [7:0]         modrm;
	logic [7:0]         sib;
	logic signed [31:0] displacement;
	logic signed [31:0] immediate;
	logic [15:0]        far_selector;
	logic [31:0]        memory_offset;
	logic [3:0]         length;

	modport source (output valid, segment_override, repeat_prefix, operand_size_flip,
		address_size_flip, opcode, modrm, sib, displacement, immediate, far_selector,
		memory_offset, length, input ready);
	modport sink (input valid, segment_override, repeat_prefix, operand_size_flip,
		address_size_flip, opcode, modrm, sib, displacement, immediate, far_selector,
		memory_offset, length, output ready);
endinterface

### design/x86fd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module x86fd_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/x86fd_step.sv
// next-state logic of the decoder: consumes one code byte against the held state
// depends on x86fd_pkg
module x86fd_step
	import x86fd_pkg::*;
(
	input  dec_state_t  cur,
	input  logic        mode32,
	input  logic [7:0]  code_byte,
	input  logic [5:0]  attr,
	output dec_state_t  nxt,
	output logic        done,
	output dec_result_t res
);

	typedef struct packed {
		logic       fin;
		phase_t     phase;
		logic [2:0] len;
	} start_t;

	// first field still wanted at or after the given stage
	function automatic start_t begin_from(phase_t stage, logic [5:0] a, logic a32);
		start_t r;
		r = '{fin: 1'b0, phase: PH_PREFIX, len: 3'd0};
		if (stage <= PH_IMM && a[AT_IMM32]) begin
			r.phase = PH_IMM;
			r.len = 3'd4;
		end else if (stage <= PH_IMM && a[AT_IMM16]) begin
			r.phase = PH_IMM;
			r.len = 3'd2;
		end else if (stage <= PH_IMM && a[AT_IMM8]) begin
			r.phase = PH_IMM;
			r.len = 3'd1;
		end else if (stage <= PH_PTR && a[AT_PTR16]) begin
			r.phase = PH_PTR;
			r.len = 3'd2;
		end else if (a[AT_MOFFS]) begin
			r.phase = PH_MOFFS;
			r.len = a32 ? 3'd4 : 3'd2;
		end else begin
			r.fin = 1'b1;
		end
		return r;
	endfunction

	dec_state_t  s;
	start_t      st;
	logic        take_st;
	logic        take_disp;
	logic        is_opc;
	logic [8:0]  opc;
	logic [2:0]  dlen;
	logic        a32;
	logic [1:0]  md;
	logic [2:0]  rm;
	logic [31:0] v;

	always_comb begin
		s = cur;
		done = 1'b0;
		st = '{fin: 1'b0, phase: PH_PREFIX, len: 3'd0};
		take_st = 1'b0;
		take_disp = 1'b0;
		is_opc = 1'b0;
		opc = {1'b0, code_byte};
		dlen = 3'd0;
		v = cur.acc;
		md = code_byte[7:6];
		rm = code_byte[2:0];
		a32 = mode32 ^ cur.flips[FLIP_ADDR];

		if (s.count != LEN_MAX) begin
			s.count = s.count + 4'd1;
		end

		case (cur.phase)
			PH_PREFIX: begin
				case (code_byte)
					PFX_ES:     s.seg = SEG_ES;
					PFX_CS:     s.seg = SEG_CS;
					PFX_SS:     s.seg = SEG_SS;
					PFX_DS:     s.seg = SEG_DS;
					PFX_FS:     s.seg = SEG_FS;
					PFX_GS:     s.seg = SEG_GS;
					PFX_OPSIZE: s.flips[FLIP_OPER] = 1'b1;
					PFX_ADSIZE: s.flips[FLIP_ADDR] = 1'b1;
					PFX_REPNZ:  s.rep = REP_NZ;
					PFX_REPZ:   s.rep = REP_Z;
					OPC_ESCAPE: s.phase = PH_ESC;
					default:    is_opc = 1'b1;
				endcase
			end
			PH_ESC: begin
				is_opc = 1'b1;
				opc = ESC_BASE | {1'b0, code_byte};
			end
			PH_MODRM: begin
				s.modrm = code_byte;
				if (a32) begin
					if (md != 2'd3 && rm == 3'd4) begin
						s.phase = PH_SIB;
					end else begin
						take_disp = 1'b1;
						if (md == 2'd2 || (md == 2'd0 && rm == 3'd5)) begin
							dlen = 3'd4;
						end else if (md == 2'd1) begin
							dlen = 3'd1;
						end
					end
				end else begin
					take_disp = 1'b1;
					if (md == 2'd2 || (md == 2'd0 && rm == 3'd6)) begin
						dlen = 3'd2;
					end else if (md == 2'd1) begin
						dlen = 3'd1;
					end
				end
			end
			PH_SIB: begin
				// base 5 means disp32 only with mod 0, and only here
				s.sib = code_byte;
				take_disp = 1'b1;
				if (cur.modrm[7:6] == 2'd2 || (cur.modrm[7:6] == 2'd0 && rm == 3'd5)) begin
					dlen = 3'd4;
				end else if (cur.modrm[7:6] == 2'd1) begin
					dlen = 3'd1;
				end
			end
			default: begin
				s.acc = s.acc | (32'(code_byte) << {s.pos, 3'b000});
				s.pos = s.pos + 2'd1;
				if (s.left != 3'd0) begin
					s.left = s.left - 3'd1;
				end
				if (s.left == 3'd0) begin
					v = (s.len == 3'd1) ? {{24{s.acc[7]}}, s.acc[7:0]} : s.acc;
					take_st = 1'b1;
					case (cur.phase)
						PH_DISP: begin
							s.disp = v;
							st = begin_from(PH_IMM, s.attr, a32);
						end
						PH_IMM: begin
							s.imm = v;
							st = begin_from(PH_PTR, s.attr, a32);
						end
						PH_PTR: begin
							s.sel = v[15:0];
							st = begin_from(PH_MOFFS, s.attr, a32);
						end
						default: begin
							s.moffs = v;
							st.fin = 1'b1;
						end
					endcase
				end
			end
		endcase

		if (is_opc) begin
			s.opcode = opc;
			s.attr = attr;
			if (attr[AT_MODRM]) begin
				s.phase = PH_MODRM;
			end else begin
				st = begin_from(PH_IMM, attr, a32);
				take_st = 1'b1;
			end
		end

		if (take_disp) begin
			if (dlen == 3'd0) begin
				st = begin_from(PH_IMM, s.attr, a32);
				take_st = 1'b1;
			end else begin
				s.phase = PH_DISP;
				s.len = dlen;
				s.left = dlen;
				s.pos = 2'd0;
				s.acc = 32'd0;
			end
		end

		if (take_st) begin
			if (st.fin) begin
				done = 1'b1;
			end else begin
				s.phase = st.phase;
				s.len = st.len;
				s.left = st.len;
				s.pos = 2'd0;
				s.acc = 32'd0;
			end
		end
	end

	always_comb begin
		res.segment_override  = s.seg;
		res.repeat_prefix     = s.rep;
		res.operand_size_flip = s.flips[FLIP_OPER];
		res.address_size_flip = s.flips[FLIP_ADDR];
		res.opcode            = s.opcode;
		res.modrm             = s.modrm;
		res.sib               = s.sib;
		res.displacement      = s.disp;
		res.immediate         = s.imm;
		res.far_selector      = s.sel;
		res.memory_offset     = s.moffs;
		res.length            = s.count;
		nxt = done ? DEC_CLEAR : s;
	end

endmodule

### design/x86_instruction_field_decoder_core.sv
// x86 instruction field decoder: one code byte or table write per cycle, held off by the clear pass
// and by a finished result not yet taken; an item passes the input stage, then the result reg
// the attribute ram read is registered, which sets the input stage; nothing loops over cycles
// reset: decode state and mode32 cleared, then a pass zeroes all 512 entries of the attribute table
// with code.ready low; configuration writes are taken during the pass
module x86_instruction_field_decoder_core
	import x86fd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	x86fd_code_if.sink            code,
	x86fd_result_if.source        result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int AW = $clog2(OPCODE_SPACE);

	logic          mode32_q;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	logic          valid_s1;
	logic          op_s1;
	logic [7:0]    byte_s1;

	dec_state_t    st_q;
	dec_state_t    st_nxt;
	dec_result_t   res;
	dec_result_t   res_q;
	logic          res_valid_q;
	logic          step_done;

	logic [5:0]    attr_rd;
	logic          accept;
	logic          done_s1;
	logic          advance;
	logic          byte_s1_live;
	phase_t        phase_eff;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [5:0]    ram_wdata;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MODE32) ? {31'd0, mode32_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode32_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == REG_MODE32) begin
			mode32_q <= pwdata[0];
		end
	end

	// handshake and stage control
	assign byte_s1_live = valid_s1 && op_s1 == OP_BYTE;
	assign done_s1      = byte_s1_live && step_done;
	assign advance      = !done_s1 || !res_valid_q || result.ready;
	assign code.ready   = !clr_q && (!valid_s1 || advance);
	assign accept       = code.valid && code.ready;

	// the opcode lookup must see the phase the held byte leaves behind
	assign phase_eff = byte_s1_live ? st_nxt.phase : st_q.phase;

	assign ram_we    = clr_q || (accept && code.op == OP_TABLE);
	assign ram_waddr = clr_q ? clr_addr_q : code.table_index;
	assign ram_wdata = clr_q ? 6'd0 : code.table_flags;

	x86fd_ram #(
		.WIDTH (ATTR_W),
		.DEPTH (OPCODE_SPACE)
	) u_attr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept && code.op == OP_BYTE),
		.raddr ({phase_eff == PH_ESC, code.code_byte}),
		.rdata (attr_rd)
	);

	x86fd_step u_step (
		.cur       (st_q),
		.mode32    (mode32_q),
		.code_byte (byte_s1),
		.attr      (attr_rd),
		.nxt       (st_nxt),
		.done      (step_done),
		.res       (res)
	);

	// table clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(OPCODE_SPACE - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q <= DEC_CLEAR;
			res_valid_q <= 1'b0;
		end else begin
			if (code.ready) begin
				valid_s1 <= code.valid;
			end
			if (byte_s1_live && advance) begin
				st_q <= st_nxt;
			end
			if (done_s1 && advance) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= code.op;
			byte_s1 <= code.code_byte;
		end
		if (done_s1 && advance) begin
			res_q <= res;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.segment_override  = res_q.segment_override;
	assign result.repeat_prefix     = res_q.repeat_prefix;
	assign result.operand_size_flip = res_q.operand_size_flip;
	assign result.address_size_flip = res_q.address_size_flip;
	assign result.opcode            = res_q.opcode;
	assign result.modrm             = res_q.modrm;
	assign result.sib               = res_q.sib;
	assign result.displacement      = res_q.displacement;
	assign result.immediate         = res_q.immediate;
	assign result.far_selector      = res_q.far_selector;
	assign result.memory_offset     = res_q.memory_offset;
	assign result.length            = res_q.length;

endmodule

### design/x86fd_checker.sv
// port-level checks of the x86 field decoder, bound to the top level
// depends on x86_instruction_field_decoder_core_defines.svh
`include "x86_instruction_field_decoder_core_defines.svh"

module x86fd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       code_valid,
	input logic       code_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_segment,
	input logic [1:0] res_repeat,
	input logic [3:0] res_length
);

	// a held result stays offered until taken
	`X86FD_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)

	// a fresh result comes from a code item taken into the input stage, then into the result register
	`X86FD_ASSERT_IMPLY(a_res_origin, clk, arst_n, $rose(res_valid),
		$past(code_valid && code_ready, 2))

	// every instruction has at least one byte and legal prefix codes
	`X86FD_ASSERT_IMPLY(a_res_fields, clk, arst_n, res_valid,
		res_length != 4'd0 && res_repeat != 2'd3 && res_segment != 3'd7)

endmodule

bind x86_instruction_field_decoder_core x86fd_checker u_x86fd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.code_valid  (code.valid),
	.code_ready  (code.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_segment (result.segment_override),
	.res_repeat  (result.repeat_prefix),
	.res_length  (result.length)
);

### tb/sv/x86_instruction_field_decoder_core_checker.sv
`timescale 1ns / 1ps
// checker of the x86 instruction field decoder: watches the code, result and register ports,
// predicts each decoded instruction from the accepted items and compares it with the result
// depends on x86fd_pkg and the channel interfaces in x86fd_if.sv
module x86_instruction_field_decoder_core_checker
	import x86fd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	x86fd_code_if       code,
	x86fd_result_if     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int unsigned errors,
	output int unsigned pending
);

	localparam logic [2:0] MODE32_ADDR = {REG_MODE32, 2'b00};

	// decoder copy
	logic        mode32_q;
	logic [5:0]  attr_table [OPCODE_SPACE];
	phase_t      stage;
	logic [2:0]  fld_left;
	logic [2:0]  fld_len;
	logic [1:0]  fld_at;
	logic [31:0] fld_bits;
	logic [3:0]  insn_len;
	logic [2:0]  seg;
	logic [1:0]  rep;
	logic [1:0]  flips;
	logic [8:0]  opc;
	logic [7:0]  modrm_q;
	logic [7:0]  sib_q;
	logic [5:0]  attr;
	logic [31:0] disp_q;
	logic [31:0] imm_q;
	logic [15:0] sel_q;
	logic [31:0] moffs_q;

	dec_result_t decoded [$];

	function automatic void clear_insn();
		stage = PH_PREFIX;
		fld_left = '0;
		fld_len = '0;
		fld_at = '0;
		fld_bits = '0;
		insn_len = '0;
		seg = '0;
		rep = '0;
		flips = '0;
		opc = '0;
		modrm_q = '0;
		sib_q = '0;
		attr = '0;
		disp_q = '0;
		imm_q = '0;
		sel_q = '0;
		moffs_q = '0;
	endfunction

	// mode32 is looked at live, every time it matters
	function automatic logic wide_addr();
		return mode32_q ^ flips[FLIP_ADDR];
	endfunction

	function automatic void open_field(phase_t p, logic [2:0] n);
		stage = p;
		fld_len = n;
		fld_left = n;
		fld_at = '0;
		fld_bits = '0;
	endfunction

	// opens the first field the attributes still call for from stage p on; 1 when none is left
	function automatic logic open_next(phase_t p);
		if (p <= PH_IMM) begin
			if (attr[AT_IMM32]) begin
				open_field(PH_IMM, 3'd4);
				return 1'b0;
			end
			if (attr[AT_IMM16]) begin
				open_field(PH_IMM, 3'd2);
				return 1'b0;
			end
			if (attr[AT_IMM8]) begin
				open_field(PH_IMM, 3'd1);
				return 1'b0;
			end
		end
		if (p <= PH_PTR && attr[AT_PTR16]) begin
			open_field(PH_PTR, 3'd2);
			return 1'b0;
		end
		if (attr[AT_MOFFS]) begin
			open_field(PH_MOFFS, wide_addr() ? 3'd4 : 3'd2);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic open_disp(logic [2:0] n);
		if (n == 0)
			return open_next(PH_IMM);
		open_field(PH_DISP, n);
		return 1'b0;
	endfunction

	function automatic logic take_opcode(logic [8:0] o);
		opc = o;
		attr = attr_table[o];
		if (attr[AT_MODRM]) begin
			stage = PH_MODRM;
			return 1'b0;
		end
		return open_next(PH_IMM);
	endfunction

	function automatic logic take_modrm(logic [7:0] b);
		logic [1:0] md;
		logic [2:0] rm;
		md = b[7:6];
		rm = b[2:0];
		modrm_q = b;
		if (wide_addr()) begin
			if (md != 2'd3 && rm == 3'd4) begin
				stage = PH_SIB;
				return 1'b0;
			end
			if (md == 2'd2 || (md == 2'd0 && rm == 3'd5))
				return open_disp(3'd4);
			return open_disp(md == 2'd1 ? 3'd1 : 3'd0);
		end
		if (md == 2'd2 || (md == 2'd0 && rm == 3'd6))
			return open_disp(3'd2);
		return open_disp(md == 2'd1 ? 3'd1 : 3'd0);
	endfunction

	// base 5 with mod 0 means disp32 only here, behind a real sib byte
	function automatic logic take_sib(logic [7:0] b);
		logic [1:0] md;
		md = modrm_q[7:6];
		sib_q = b;
		if (md == 2'd2 || (md == 2'd0 && b[2:0] == 3'd5))
			return open_disp(3'd4);
		return open_disp(md == 2'd1 ? 3'd1 : 3'd0);
	endfunction

	function automatic logic take_field(logic [7:0] b);
		logic [31:0] v;
		fld_bits = fld_bits | (32'(b) << (8 * fld_at));
		fld_at = fld_at + 2'd1;
		if (fld_left != 0)
			fld_left = fld_left - 3'd1;
		if (fld_left != 0)
			return 1'b0;
		v = (fld_len == 3'd1) ? {{24{fld_bits[7]}}, fld_bits[7:0]} : fld_bits;
		case (stage)
			PH_DISP: begin
				disp_q = v;
				return open_next(PH_IMM);
			end
			PH_IMM: begin
				imm_q = v;
				return open_next(PH_PTR);
			end
			PH_PTR: begin
				sel_q = v[15:0];
				return open_next(PH_MOFFS);
			end
			default: begin
				moffs_q = v;
				return 1'b1;
			end
		endcase
	endfunction

	function automatic logic decode_byte(input logic [7:0] b, output dec_result_t r);
		logic last;
		last = 1'b0;
		r = '0;
		if (insn_len != LEN_MAX)
			insn_len = insn_len + 4'd1;
		case (stage)
			PH_PREFIX: begin
				case (b)
					PFX_ES:     seg = SEG_ES;
					PFX_CS:     seg = SEG_CS;
					PFX_SS:     seg = SEG_SS;
					PFX_DS:     seg = SEG_DS;
					PFX_FS:     seg = SEG_FS;
					PFX_GS:     seg = SEG_GS;
					PFX_OPSIZE: flips[FLIP_OPER] = 1'b1;
					PFX_ADSIZE: flips[FLIP_ADDR] = 1'b1;
					PFX_REPNZ:  rep = REP_NZ;
					PFX_REPZ:   rep = REP_Z;
					OPC_ESCAPE: stage = PH_ESC;
					default:    last = take_opcode({1'b0, b});
				endcase
			end
			PH_ESC:   last = take_opcode(ESC_BASE | 9'(b));
			PH_MODRM: last = take_modrm(b);
			PH_SIB:   last = take_sib(b);
			default:  last = take_field(b);
		endcase
		if (last) begin
			r.segment_override = seg;
			r.repeat_prefix = rep;
			r.operand_size_flip = flips[FLIP_OPER];
			r.address_size_flip = flips[FLIP_ADDR];
			r.opcode = opc;
			r.modrm = modrm_q;
			r.sib = sib_q;
			r.displacement = disp_q;
			r.immediate = imm_q;
			r.far_selector = sel_q;
			r.memory_offset = moffs_q;
			r.length = insn_len;
			clear_insn();
		end
		return last;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		dec_result_t want;
		dec_result_t got;
		if (!arst_n) begin
			clear_insn();
			mode32_q = 1'b0;
			for (int i = 0; i < OPCODE_SPACE; i++)
				attr_table[i] = '0;
			decoded.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (decoded.size() == 0) begin
					errors++;
					$error("decoded item with no instruction outstanding");
				end else begin
					want = decoded.pop_front();
					compare_field("segment_override", 32'(want.segment_override),
						32'(result.segment_override));
					compare_field("repeat_prefix", 32'(want.repeat_prefix),
						32'(result.repeat_prefix));
					compare_field("operand_size_flip", 32'(want.operand_size_flip),
						32'(result.operand_size_flip));
					compare_field("address_size_flip", 32'(want.address_size_flip),
						32'(result.address_size_flip));
					compare_field("opcode", 32'(want.opcode), 32'(result.opcode));
					compare_field("modrm", 32'(want.modrm), 32'(result.modrm));
					compare_field("sib", 32'(want.sib), 32'(result.sib));
					compare_field("displacement", want.displacement, result.displacement);
					compare_field("immediate", want.immediate, result.immediate);
					compare_field("far_selector", 32'(want.far_selector),
						32'(result.far_selector));
					compare_field("memory_offset", want.memory_offset, result.memory_offset);
					compare_field("length", 32'(want.length), 32'(result.length));
				end
			end
			if (psel && penable && pwrite && pready && paddr == MODE32_ADDR)
				mode32_q = pwdata[0];
			if (code.valid && code.ready) begin
				if (code.op == OP_TABLE)
					attr_table[code.table_index] = code.table_flags;
				else if (decode_byte(code.code_byte, got))
					decoded.push_back(got);
			end
			pending = decoded.size();
		end
	end

endmodule

### tb/sv/x86_instruction_field_decoder_core_tb.sv
`timescale 1ns / 1ps
// top of the x86 instruction field decoder testbench: clock, reset, code and register stimulus,
// result back-pressure and the verdict; the checker beside the block does the comparing
// depends on x86fd_pkg, x86fd_if.sv, the block and x86_instruction_field_decoder_core_checker
module x86_instruction_field_decoder_core_tb;
	import x86fd_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned PHASES        = 6;
	localparam int unsigned PHASE_ITEMS   = 130;
	localparam logic [2:0]  MODE32_ADDR   = {REG_MODE32, 2'b00};
	localparam logic [5:0]  FL_MODRM      = 6'(1 << AT_MODRM);
	localparam logic [5:0]  FL_ALL        = '1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;

	// ten prefixes, then the escape
	logic [7:0] prefix_bytes [11] = '{PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
		PFX_OPSIZE, PFX_ADSIZE, PFX_REPNZ, PFX_REPZ, OPC_ESCAPE};

	x86fd_code_if   code ();
	x86fd_result_if result ();

	x86_instruction_field_decoder_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.code    (code),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	x86_instruction_field_decoder_core_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.code    (code),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.errors  (fail_count),
		.pending (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result back-pressure: changing stall modes, including stretches of none
	initial begin : drain
		int unsigned mode;
		int unsigned span;
		int unsigned period;
		result.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			period = $urandom_range(2, 6);
			for (int unsigned k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					0:       result.ready = 1'b1;
					1:       result.ready = 1'($urandom_range(0, 1));
					2:       result.ready = (k % period) == 0;
					default: result.ready = (k % 16) >= 12;
				endcase
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_item(logic op, logic [7:0] b, logic [8:0] idx, logic [5:0] flags);
		if (burst_left == 0) begin
			code.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		code.valid = 1'b1;
		code.op = op;
		code.code_byte = b;
		code.table_index = idx;
		code.table_flags = flags;
		do @(posedge clk); while (!code.ready);
		@(negedge clk);
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(OP_BYTE, b, 9'($urandom_range(0, 511)), 6'($urandom_range(0, 63)));
	endtask

	task automatic send_table(logic [8:0] idx, logic [5:0] flags);
		send_item(OP_TABLE, 8'($urandom_range(0, 255)), idx, flags);
	endtask

	task automatic send_seq(input logic [7:0] seq [$]);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic write_mode32(logic v);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = MODE32_ADDR;
		pwdata = {31'($urandom), v};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// stop sending until every instruction is out and the pipeline is empty
	task automatic settle();
		code.valid = 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 99) < 22)
			return prefix_bytes[$urandom_range(0, 10)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [5:0] pick_flags();
		if ($urandom_range(0, 99) < 15)
			return '0;
		return 6'($urandom_range(0, 63));
	endfunction

	initial begin : stimulus
		int unsigned r;
		int unsigned n;
		int unsigned k;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		code.valid = 1'b0;
		code.op = OP_BYTE;
		code.code_byte = '0;
		code.table_index = '0;
		code.table_flags = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 16-bit default: prefixes, disp8 under an address-size flip, disp16, immediate priority
		write_mode32(1'b0);
		send_table(9'h08b, FL_MODRM);
		send_table(9'h1ff, FL_ALL);
		send_seq('{8'h00});
		send_seq('{PFX_ES, PFX_GS, PFX_OPSIZE, PFX_ADSIZE, PFX_REPZ, 8'h8b, 8'h46, 8'h80});
		send_seq('{8'h8b, 8'h06, 8'h34, 8'h12});
		send_seq('{OPC_ESCAPE, 8'hff, 8'hc0, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
			8'h77, 8'h88});
		settle();

		// 32-bit default: sib with base 5, then 16-bit addressing where rm 4 has no sib
		write_mode32(1'b1);
		send_seq('{8'h8b, 8'h04, 8'h25, 8'h78, 8'h56, 8'h34, 8'h12});
		send_seq('{PFX_ADSIZE, 8'h8b, 8'h04, 8'h25});

		for (int i = 0; i < OPCODE_SPACE; i++)
			send_table(9'(i), pick_flags());

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_mode32(1'(p));
			n = 0;
			while (n < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					send_table(9'($urandom_range(0, 511)), pick_flags());
				end else if (r < 5) begin
					// prefix run long enough to saturate the length
					k = $urandom_range(14, 20);
					repeat (k) send_byte(prefix_bytes[$urandom_range(0, 9)]);
					n += k;
				end else if (r == 5) begin
					code.valid = 1'b0;
					do @(negedge clk); while (pending != 0);
				end else begin
					send_byte(pick_byte());
					n++;
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### x86_instruction_field_decoder_core.f
+incdir+design
design/x86fd_pkg.sv
design/x86fd_if.sv
design/x86fd_ram.sv
design/x86fd_step.sv
design/x86_instruction_field_decoder_core.sv
design/x86fd_checker.sv
tb/sv/x86_instruction_field_decoder_core_checker.sv
tb/sv/x86_instruction_field_decoder_core_tb.sv
